[hw/rtl/cmts_pkg.sv]
// Shared types, constants and the format rank table of the camera media-type selector.
package cmts_pkg;

    // Field and register widths
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIM_W  = 16;
    localparam int unsigned FPS_W  = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned RANK_W = 3;
    localparam int unsigned AREA_W = 64;

    // Register reset values
    localparam logic [DIM_W-1:0] MAX_DIM_RST  = 16'd4096;
    localparam logic [DIM_W-1:0] SOFT_W_RST   = 16'd1920;
    localparam logic [DIM_W-1:0] SOFT_H_RST   = 16'd1080;
    localparam logic [FPS_W-1:0] SOFT_FPS_RST = 8'd30;

    // Count saturation point
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Legal record flag values
    localparam logic [7:0] FLAGS_ONE = 8'h01;
    localparam logic [7:0] FLAGS_TWO = 8'h02;

    // Format codes
    localparam logic [7:0] FMT_H264  = 8'd1;
    localparam logic [7:0] FMT_MJPG  = 8'd2;
    localparam logic [7:0] FMT_YUY2  = 8'd3;
    localparam logic [7:0] FMT_NV12  = 8'd4;
    localparam logic [7:0] FMT_I420  = 8'd5;
    localparam logic [7:0] FMT_RGB24 = 8'd6;
    localparam logic [7:0] FMT_RGB32 = 8'd7;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_MAX_DIM  = 2'd0,
        REG_SOFT_W   = 2'd1,
        REG_SOFT_H   = 2'd2,
        REG_SOFT_FPS = 2'd3
    } reg_idx_t;

    // One offered media-type record
    typedef struct packed {
        logic [7:0]  fmt_code;
        logic [31:0] pic_width;
        logic [31:0] pic_height;
        logic [31:0] rate_num;
        logic [31:0] rate_den;
        logic [31:0] aspect_num;
        logic [31:0] aspect_den;
        logic [7:0]  media_flags;
    } media_rec_t;

    // Record after validity, class, rank and area are worked out
    typedef struct packed {
        media_rec_t          rec;
        logic                ok;
        logic                soft_ok;
        logic [RANK_W-1:0]   rank;
        logic [AREA_W-1:0]   area;
        logic                last;
    } judged_t;

    // Preference rank of a format code; 0 marks an unknown code
    function automatic logic [RANK_W-1:0] fmt_rank(input logic [7:0] code);
        logic [RANK_W-1:0] r;
        begin
            case (code)
                FMT_MJPG:  r = 3'd7;
                FMT_NV12:  r = 3'd6;
                FMT_YUY2:  r = 3'd5;
                FMT_I420:  r = 3'd4;
                FMT_RGB32: r = 3'd3;
                FMT_RGB24: r = 3'd2;
                FMT_H264:  r = 3'd1;
                default:   r = 3'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[hw/rtl/cmts_channels.sv]
// Valid/ready channel interfaces for offered records and selection results.
interface cmts_offer_if;
    logic        valid;
    logic        ready;
    logic [7:0]  fmt_code;
    logic [31:0] pic_width;
    logic [31:0] pic_height;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [31:0] aspect_num;
    logic [31:0] aspect_den;
    logic [7:0]  media_flags;
    logic        last_record;

    modport source (
        output valid, fmt_code, pic_width, pic_height, rate_num, rate_den,
               aspect_num, aspect_den, media_flags, last_record,
        input  ready
    );
    modport sink (
        input  valid, fmt_code, pic_width, pic_height, rate_num, rate_den,
               aspect_num, aspect_den, media_flags, last_record,
        output ready
    );
endinterface

interface cmts_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  best_fmt;
    logic [31:0] best_width;
    logic [31:0] best_height;
    logic [31:0] best_rate_num;
    logic [31:0] best_rate_den;
    logic [31:0] best_aspect_num;
    logic [31:0] best_aspect_den;
    logic [7:0]  best_flags;
    logic [15:0] valid_count;
    logic        none_found;

    modport source (
        output valid, best_fmt, best_width, best_height, best_rate_num, best_rate_den,
               best_aspect_num, best_aspect_den, best_flags, valid_count, none_found,
        input  ready
    );
    modport sink (
        input  valid, best_fmt, best_width, best_height, best_rate_num, best_rate_den,
               best_aspect_num, best_aspect_den, best_flags, valid_count, none_found,
        output ready
    );
endinterface

[hw/rtl/camera_media_type_selector_unit.sv]
// Camera media-type selector: keeps the best valid record of a run and reports it.
//
// Takes one media-type record word per cycle unless stalled and emits one
// result word on the record marked last. The pipeline has three register
// levels: the input register, the judged-record register (validity, soft
// class, rank and the 32x32 area product) and the result register, which a
// last record passes through in that order. Throughput is one record per
// cycle when nothing stalls, set by the compare and update against the kept
// best in the second stage. Records that are not last flow past a waiting
// result; a last record reaching stage two waits until the output register is
// free, and the input stalls once stage one fills behind it. Registers sit on
// an APB port at byte offsets 0, 4, 8 and 12 (max dimension, soft width, soft
// height, soft fps) and should be written only while no run is in flight.
module camera_media_type_selector_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmts_pkg::ADDR_W-1:0]   paddr,
    input  logic [cmts_pkg::DATA_W-1:0]   pwdata,
    output logic [cmts_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    cmts_offer_if.sink                    offer,
    cmts_result_if.source                 result
);

    // Configuration registers
    logic [cmts_pkg::DIM_W-1:0] max_dim_reg;
    logic [cmts_pkg::DIM_W-1:0] soft_w_reg;
    logic [cmts_pkg::DIM_W-1:0] soft_h_reg;
    logic [cmts_pkg::FPS_W-1:0] soft_fps_reg;

    logic               cfg_wr;
    cmts_pkg::reg_idx_t cfg_idx;

    // Pipeline control and data
    logic                 s1_valid_reg;
    cmts_pkg::media_rec_t s1_rec_reg;
    logic                 s1_last_reg;
    logic                 s2_valid_reg;
    cmts_pkg::judged_t    s2_reg;
    cmts_pkg::judged_t    s1_judged;

    logic offer_acc;
    logic s1_adv;
    logic s2_fire;
    logic out_free;

    // Kept best of the run
    logic                         kept_present_reg;
    logic                         kept_soft_reg;
    logic [cmts_pkg::RANK_W-1:0]  kept_rank_reg;
    logic [cmts_pkg::AREA_W-1:0]  kept_area_reg;
    cmts_pkg::media_rec_t         kept_rec_reg;
    logic [cmts_pkg::CNT_W-1:0]   count_reg;

    logic                         take;
    logic                         upd;
    logic                         present_next;
    logic [cmts_pkg::CNT_W-1:0]   count_next;
    cmts_pkg::media_rec_t         rec_next;

    // Result register
    logic                         out_valid_reg;
    cmts_pkg::media_rec_t         out_rec_reg;
    logic [cmts_pkg::CNT_W-1:0]   out_count_reg;
    logic                         out_none_reg;

    // Stage-one arithmetic
    logic [cmts_pkg::RANK_W-1:0]  s1_rank;
    logic                         s1_flags_ok;
    logic                         s1_dims_ok;
    logic [39:0]                  fps_prod;
    logic [cmts_pkg::AREA_W-1:0]  s1_area;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cmts_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dim_reg  <= cmts_pkg::MAX_DIM_RST;
            soft_w_reg   <= cmts_pkg::SOFT_W_RST;
            soft_h_reg   <= cmts_pkg::SOFT_H_RST;
            soft_fps_reg <= cmts_pkg::SOFT_FPS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                cmts_pkg::REG_MAX_DIM:  max_dim_reg  <= pwdata[cmts_pkg::DIM_W-1:0];
                cmts_pkg::REG_SOFT_W:   soft_w_reg   <= pwdata[cmts_pkg::DIM_W-1:0];
                cmts_pkg::REG_SOFT_H:   soft_h_reg   <= pwdata[cmts_pkg::DIM_W-1:0];
                cmts_pkg::REG_SOFT_FPS: soft_fps_reg <= pwdata[cmts_pkg::FPS_W-1:0];
                default:                ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            cmts_pkg::REG_MAX_DIM:  prdata = {16'd0, max_dim_reg};
            cmts_pkg::REG_SOFT_W:   prdata = {16'd0, soft_w_reg};
            cmts_pkg::REG_SOFT_H:   prdata = {16'd0, soft_h_reg};
            cmts_pkg::REG_SOFT_FPS: prdata = {24'd0, soft_fps_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign out_free    = !out_valid_reg || result.ready;
    assign s2_fire     = s2_valid_reg && (!s2_reg.last || out_free);
    assign s1_adv      = !s2_valid_reg || s2_fire;
    assign offer.ready = !s1_valid_reg || s1_adv;
    assign offer_acc   = offer.valid && offer.ready;

    // ---------------- stage one: input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (offer.ready)
        begin
            s1_valid_reg <= offer.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (offer_acc)
        begin
            s1_rec_reg.fmt_code    <= offer.fmt_code;
            s1_rec_reg.pic_width   <= offer.pic_width;
            s1_rec_reg.pic_height  <= offer.pic_height;
            s1_rec_reg.rate_num    <= offer.rate_num;
            s1_rec_reg.rate_den    <= offer.rate_den;
            s1_rec_reg.aspect_num  <= offer.aspect_num;
            s1_rec_reg.aspect_den  <= offer.aspect_den;
            s1_rec_reg.media_flags <= offer.media_flags;
            s1_last_reg            <= offer.last_record;
        end
    end

    // Validity, soft class, rank, area (one 32x32 and one 8x32 product)
    assign s1_rank     = cmts_pkg::fmt_rank(s1_rec_reg.fmt_code);
    assign s1_flags_ok = s1_rec_reg.media_flags inside {cmts_pkg::FLAGS_ONE, cmts_pkg::FLAGS_TWO};
    assign s1_dims_ok  = (s1_rec_reg.pic_width != '0) && (s1_rec_reg.pic_height != '0) &&
                         (s1_rec_reg.pic_width  <= {16'd0, max_dim_reg}) &&
                         (s1_rec_reg.pic_height <= {16'd0, max_dim_reg});
    assign fps_prod    = {32'd0, soft_fps_reg} * {8'd0, s1_rec_reg.rate_den};
    assign s1_area     = {32'd0, s1_rec_reg.pic_width} * {32'd0, s1_rec_reg.pic_height};

    always_comb
    begin
        s1_judged.rec     = s1_rec_reg;
        s1_judged.ok      = (s1_rank != '0) && s1_flags_ok && s1_dims_ok &&
                            (s1_rec_reg.rate_num != '0) && (s1_rec_reg.rate_den != '0);
        s1_judged.soft_ok = (s1_rec_reg.pic_width  <= {16'd0, soft_w_reg}) &&
                            (s1_rec_reg.pic_height <= {16'd0, soft_h_reg}) &&
                            ({8'd0, s1_rec_reg.rate_num} <= fps_prod);
        s1_judged.rank    = s1_rank;
        s1_judged.area    = s1_area;
        s1_judged.last    = s1_last_reg;
    end

    // ---------------- stage two: judged register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            s2_reg <= s1_judged;
        end
    end

    // Compare against kept best: soft class, then rank, then strictly larger area
    always_comb
    begin
        if (!kept_present_reg)
            take = 1'b1;
        else if (s2_reg.soft_ok != kept_soft_reg)
            take = s2_reg.soft_ok;
        else if (s2_reg.rank != kept_rank_reg)
            take = s2_reg.rank > kept_rank_reg;
        else
            take = s2_reg.area > kept_area_reg;
    end

    assign upd          = s2_reg.ok && take;
    assign present_next = kept_present_reg || s2_reg.ok;
    assign count_next   = (s2_reg.ok && (count_reg != cmts_pkg::CNT_MAX)) ?
                          count_reg + 1'b1 : count_reg;
    assign rec_next     = upd ? s2_reg.rec : kept_rec_reg;

    // Run state: cleared after the last record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_present_reg <= 1'b0;
            count_reg        <= '0;
        end
        else if (s2_fire)
        begin
            if (s2_reg.last)
            begin
                kept_present_reg <= 1'b0;
                count_reg        <= '0;
            end
            else
            begin
                kept_present_reg <= present_next;
                count_reg        <= count_next;
            end
        end
    end

    // Kept record payload, meaningful only while kept_present_reg is set
    always_ff @(posedge clk)
    begin
        if (s2_fire && upd)
        begin
            kept_rec_reg  <= s2_reg.rec;
            kept_soft_reg <= s2_reg.soft_ok;
            kept_rank_reg <= s2_reg.rank;
            kept_area_reg <= s2_reg.area;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire && s2_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && s2_reg.last)
        begin
            out_rec_reg   <= present_next ? rec_next : '0;
            out_count_reg <= count_next;
            out_none_reg  <= !present_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.best_fmt        = out_rec_reg.fmt_code;
    assign result.best_width      = out_rec_reg.pic_width;
    assign result.best_height     = out_rec_reg.pic_height;
    assign result.best_rate_num   = out_rec_reg.rate_num;
    assign result.best_rate_den   = out_rec_reg.rate_den;
    assign result.best_aspect_num = out_rec_reg.aspect_num;
    assign result.best_aspect_den = out_rec_reg.aspect_den;
    assign result.best_flags      = out_rec_reg.media_flags;
    assign result.valid_count     = out_count_reg;
    assign result.none_found      = out_none_reg;

`ifndef SYNTH
    // A kept record exists exactly when the run has counted a valid record
    a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
        kept_present_reg == (count_reg != '0))
        else $error("kept record and valid count disagree");

    // Run state is empty after the last record leaves stage two
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && s2_reg.last) |=> (!kept_present_reg && count_reg == '0))
        else $error("run state not cleared after last record");

    // A new result only follows a last record leaving stage two
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_fire && s2_reg.last))
        else $error("result raised without a last record");

    // none_found agrees with the reported count
    a_none_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_none_reg == (out_count_reg == '0)))
        else $error("none_found inconsistent with valid_count");

    // A held stage-one word is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stalled record lost from stage one");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the camera media-type selector unit.
module testbench;

    localparam int          LIMIT       = 600000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 8;
    localparam logic [7:0]  FMT_NONE    = 8'd0;
    localparam logic [7:0]  FMT_BEYOND  = 8'd8;
    localparam logic [7:0]  FLAGS_NONE  = 8'h00;
    localparam logic [7:0]  FLAGS_BAD   = 8'h03;
    localparam logic [31:0] DIM_KEEP    = 32'h0000_FFFF;
    localparam logic [31:0] FPS_KEEP    = 32'h0000_00FF;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    // One record word plus its end-of-list mark
    typedef struct {
        cmts_pkg::media_rec_t rec;
        logic                 last;
    } offer_t;

    // What the block should report for one list
    typedef struct {
        cmts_pkg::media_rec_t rec;
        logic [15:0]          count;
        logic                 none;
    } selection_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [cmts_pkg::ADDR_W-1:0] paddr;
    logic [cmts_pkg::DATA_W-1:0] pwdata;
    logic [cmts_pkg::DATA_W-1:0] prdata;
    logic pready;

    cmts_offer_if  offer_bus ();
    cmts_result_if result_bus ();

    camera_media_type_selector_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .offer   (offer_bus),
        .result  (result_bus)
    );

    // Register copies used by the selector model and the record generator
    logic [15:0] lim_dim = cmts_pkg::MAX_DIM_RST;
    logic [15:0] lim_w   = cmts_pkg::SOFT_W_RST;
    logic [15:0] lim_h   = cmts_pkg::SOFT_H_RST;
    logic [7:0]  lim_fps = cmts_pkg::SOFT_FPS_RST;

    // Best-so-far state of the selector model
    cmts_pkg::media_rec_t best_rec   = '0;
    logic                 best_held  = 1'b0;
    logic                 best_soft  = 1'b0;
    logic [2:0]           best_rank  = 3'd0;
    logic [63:0]          best_area  = 64'd0;
    logic [15:0]          valid_seen = 16'd0;

    offer_t     offer_q[$];
    selection_t selections_due[$];
    offer_t     on_wire;

    int  n_pushed   = 0;
    int  n_taken    = 0;
    int  n_lists    = 0;
    int  n_checked  = 0;
    int  n_writes   = 0;
    int  n_blocked  = 0;
    int  n_errors   = 0;
    int  cycles     = 0;
    int  send_gap   = 0;
    int  recv_gap   = 0;
    int  hold_left  = 0;
    bit  hold_req   = 1'b0;
    bit  hold_used  = 1'b0;
    bit  jitter     = 1'b1;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    function automatic logic [2:0] rank_of(input logic [7:0] code);
        case (code)
            cmts_pkg::FMT_MJPG:  return 3'd7;
            cmts_pkg::FMT_NV12:  return 3'd6;
            cmts_pkg::FMT_YUY2:  return 3'd5;
            cmts_pkg::FMT_I420:  return 3'd4;
            cmts_pkg::FMT_RGB32: return 3'd3;
            cmts_pkg::FMT_RGB24: return 3'd2;
            cmts_pkg::FMT_H264:  return 3'd1;
            default:             return 3'd0;
        endcase
    endfunction

    // Selector model: judge one accepted record, queue a selection on the last one
    function automatic void judge_record(input offer_t o);
        logic [2:0]  r;
        logic        ok;
        logic        soft_ok;
        logic        take;
        logic [63:0] area;
        selection_t  s;
        r  = rank_of(o.rec.fmt_code);
        ok = (r != 3'd0)
             && (o.rec.media_flags == cmts_pkg::FLAGS_ONE
                 || o.rec.media_flags == cmts_pkg::FLAGS_TWO)
             && (o.rec.pic_width != 32'd0) && (o.rec.pic_height != 32'd0)
             && (o.rec.pic_width <= {16'd0, lim_dim})
             && (o.rec.pic_height <= {16'd0, lim_dim})
             && (o.rec.rate_num != 32'd0) && (o.rec.rate_den != 32'd0);
        if (ok)
        begin
            soft_ok = (o.rec.pic_width <= {16'd0, lim_w})
                      && (o.rec.pic_height <= {16'd0, lim_h})
                      && ({32'd0, o.rec.rate_num}
                          <= {56'd0, lim_fps} * {32'd0, o.rec.rate_den});
            area = {32'd0, o.rec.pic_width} * {32'd0, o.rec.pic_height};
            if (valid_seen != cmts_pkg::CNT_MAX)
                valid_seen++;
            if (!best_held)
                take = 1'b1;
            else if (soft_ok != best_soft)
                take = soft_ok;
            else if (r != best_rank)
                take = r > best_rank;
            else
                take = area > best_area;
            if (take)
            begin
                best_rec  = o.rec;
                best_held = 1'b1;
                best_soft = soft_ok;
                best_rank = r;
                best_area = area;
            end
        end
        if (o.last)
        begin
            s.rec   = best_rec;
            s.count = valid_seen;
            s.none  = !best_held;
            selections_due.push_back(s);
            n_lists++;
            best_rec   = '0;
            best_held  = 1'b0;
            best_soft  = 1'b0;
            best_rank  = 3'd0;
            best_area  = 64'd0;
            valid_seen = 16'd0;
        end
    endfunction

    // Compare one accepted result word with the oldest pending selection
    task automatic check_selection();
        selection_t s;
        if (selections_due.size() == 0)
        begin
            report_error("result word with no selection pending");
        end
        else
        begin
            s = selections_due.pop_front();
            n_checked++;
            compare_field("best_fmt", 64'(result_bus.best_fmt), 64'(s.rec.fmt_code));
            compare_field("best_width", 64'(result_bus.best_width), 64'(s.rec.pic_width));
            compare_field("best_height", 64'(result_bus.best_height),
                          64'(s.rec.pic_height));
            compare_field("best_rate_num", 64'(result_bus.best_rate_num),
                          64'(s.rec.rate_num));
            compare_field("best_rate_den", 64'(result_bus.best_rate_den),
                          64'(s.rec.rate_den));
            compare_field("best_aspect_num", 64'(result_bus.best_aspect_num),
                          64'(s.rec.aspect_num));
            compare_field("best_aspect_den", 64'(result_bus.best_aspect_den),
                          64'(s.rec.aspect_den));
            compare_field("best_flags", 64'(result_bus.best_flags),
                          64'(s.rec.media_flags));
            compare_field("valid_count", 64'(result_bus.valid_count), 64'(s.count));
            compare_field("none_found", 64'(result_bus.none_found), 64'(s.none));
        end
    endtask

    // Record driver: judges accepted words, then offers the next one or idles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (offer_bus.valid && offer_bus.ready)
            begin
                judge_record(on_wire);
                n_taken++;
            end
            if (offer_bus.valid && !offer_bus.ready)
                n_blocked++;
            if (!offer_bus.valid || offer_bus.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    offer_bus.valid <= 1'b0;
                end
                else if (jitter && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 10);
                    offer_bus.valid <= 1'b0;
                end
                else if (offer_q.size() != 0)
                begin
                    on_wire = offer_q.pop_front();
                    offer_bus.fmt_code    <= on_wire.rec.fmt_code;
                    offer_bus.pic_width   <= on_wire.rec.pic_width;
                    offer_bus.pic_height  <= on_wire.rec.pic_height;
                    offer_bus.rate_num    <= on_wire.rec.rate_num;
                    offer_bus.rate_den    <= on_wire.rec.rate_den;
                    offer_bus.aspect_num  <= on_wire.rec.aspect_num;
                    offer_bus.aspect_den  <= on_wire.rec.aspect_den;
                    offer_bus.media_flags <= on_wire.rec.media_flags;
                    offer_bus.last_record <= on_wire.last;
                    offer_bus.valid       <= 1'b1;
                end
                else
                begin
                    offer_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, started once by the stimulus
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: checks accepted words and drives ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
                check_selection();
            if (hold_left != 0)
                result_bus.ready <= 1'b0;
            else if (recv_gap != 0)
            begin
                recv_gap--;
                result_bus.ready <= 1'b0;
            end
            else if (jitter && $urandom_range(0, 3) == 0)
            begin
                recv_gap = $urandom_range(0, 10);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // APB write, then read back the masked value
    task automatic write_reg(input cmts_pkg::reg_idx_t idx, input logic [31:0] value,
                             input logic [31:0] keep);
        logic [31:0] data;
        data = ($urandom & ~keep) | (value & keep);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            cmts_pkg::REG_MAX_DIM:  lim_dim = data[15:0];
            cmts_pkg::REG_SOFT_W:   lim_w   = data[15:0];
            cmts_pkg::REG_SOFT_H:   lim_h   = data[15:0];
            cmts_pkg::REG_SOFT_FPS: lim_fps = data[7:0];
            default:                ;
        endcase
        n_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== (data & keep))
            report_error($sformatf("register %s reads %0h, should be %0h",
                                   idx.name(), prdata, data & keep));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] dim, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] fps);
        write_reg(cmts_pkg::REG_MAX_DIM,  {16'd0, dim}, DIM_KEEP);
        write_reg(cmts_pkg::REG_SOFT_W,   {16'd0, w},   DIM_KEEP);
        write_reg(cmts_pkg::REG_SOFT_H,   {16'd0, h},   DIM_KEEP);
        write_reg(cmts_pkg::REG_SOFT_FPS, {24'd0, fps}, FPS_KEEP);
    endtask

    function automatic void queue_record(input offer_t o);
        offer_q.push_back(o);
        n_pushed++;
    endfunction

    task automatic add_record(input logic [7:0] fmt, input logic [31:0] w,
                              input logic [31:0] h, input logic [31:0] rn,
                              input logic [31:0] rd, input logic [31:0] an,
                              input logic [31:0] ad, input logic [7:0] fl,
                              input logic last);
        offer_t o;
        o.rec  = '{fmt, w, h, rn, rd, an, ad, fl};
        o.last = last;
        queue_record(o);
    endtask

    // Size near the hard and soft limits, or anywhere
    function automatic logic [31:0] pick_size(input logic [15:0] hard, input logic [15:0] pref);
        logic [15:0] top;
        case ($urandom_range(0, 23))
            0: return 32'd0;
            1: return 32'd1;
            2: return {16'd0, hard};
            3: return {16'd0, hard} + 32'd1;
            4: return {16'd0, pref};
            5: return {16'd0, pref} + 32'd1;
            6: return $urandom;
            7: return ALL_ONES;
            default:
            begin
                top = (pref != 0 && pref < hard && $urandom_range(0, 1) == 1) ? pref : hard;
                return (top == 0) ? 32'd1 : $urandom_range(1, top);
            end
        endcase
    endfunction

    // Random record, mostly well formed, sized around the current limits
    function automatic offer_t make_record(input logic is_last);
        offer_t      o;
        logic [63:0] ceiling;
        int          pick;
        case ($urandom_range(0, 11))
            0:       o.rec.fmt_code = FMT_NONE;
            1:       o.rec.fmt_code = FMT_BEYOND;
            2:       o.rec.fmt_code = 8'($urandom_range(0, 255));
            default: o.rec.fmt_code = 8'($urandom_range(cmts_pkg::FMT_H264,
                                                        cmts_pkg::FMT_RGB32));
        endcase
        o.rec.pic_width  = pick_size(lim_dim, lim_w);
        o.rec.pic_height = pick_size(lim_dim, lim_h);
        case ($urandom_range(0, 11))
            0:       o.rec.rate_den = 32'd0;
            1:       o.rec.rate_den = $urandom;
            2:       o.rec.rate_den = ALL_ONES;
            default: o.rec.rate_den = $urandom_range(1, 1001);
        endcase
        // numerator around the soft fps ceiling
        ceiling = {56'd0, lim_fps} * {32'd0, o.rec.rate_den};
        pick = $urandom_range(0, 11);
        case (pick)
            0: o.rec.rate_num = 32'd0;
            1: o.rec.rate_num = $urandom;
            2: o.rec.rate_num = ALL_ONES;
            3: ceiling = ceiling + 64'd1;
            4: ceiling = ceiling - 64'd1;
            5: ;
            default: ceiling = ceiling >> $urandom_range(1, 3);
        endcase
        if (pick > 2)
            o.rec.rate_num = (ceiling == 64'd0 || ceiling > {32'd0, ALL_ONES})
                             ? $urandom_range(1, 1000) : ceiling[31:0];
        o.rec.aspect_num = $urandom;
        o.rec.aspect_den = $urandom;
        case ($urandom_range(0, 11))
            0:       o.rec.media_flags = FLAGS_NONE;
            1:       o.rec.media_flags = FLAGS_BAD;
            2:       o.rec.media_flags = 8'($urandom_range(0, 255));
            default: o.rec.media_flags = $urandom_range(0, 1) ? cmts_pkg::FLAGS_TWO
                                                              : cmts_pkg::FLAGS_ONE;
        endcase
        o.last = is_last;
        return o;
    endfunction

    task automatic fill_lists(input int n_items, input int longest);
        int len;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, longest);
            for (int k = 0; k < len; k++)
                queue_record(make_record(k == len - 1));
            sent += len;
        end
    endtask

    // Wait for every word to be taken and every selection to arrive
    task automatic drain();
        do @(posedge clk); while (n_taken != n_pushed || selections_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        offer_bus.valid       = 1'b0;
        offer_bus.fmt_code    = '0;
        offer_bus.pic_width   = '0;
        offer_bus.pic_height  = '0;
        offer_bus.rate_num    = '0;
        offer_bus.rate_den    = '0;
        offer_bus.aspect_num  = '0;
        offer_bus.aspect_den  = '0;
        offer_bus.media_flags = '0;
        offer_bus.last_record = 1'b0;
        result_bus.ready      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lists at reset limits (4096, 1920x1080, 30 fps)
        // lone unknown format: nothing found
        add_record(FMT_NONE, 640, 480, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b1);
        // rank climbs through every format, then area decides
        add_record(cmts_pkg::FMT_H264,  1920, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_RGB24, 1920, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_TWO, 1'b0);
        add_record(cmts_pkg::FMT_RGB32, 1920, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_I420,  1920, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_TWO, 1'b0);
        add_record(cmts_pkg::FMT_YUY2,  1920, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_NV12,  1920, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_TWO, 1'b0);
        add_record(cmts_pkg::FMT_MJPG,  640, 480, 30, 1, 0, 0, cmts_pkg::FLAGS_TWO, 1'b0);
        add_record(cmts_pkg::FMT_MJPG,  1280, 720, 30, 1, ALL_ONES, ALL_ONES,
                   cmts_pkg::FLAGS_ONE, 1'b0);
        // equal area but taller than the soft height: outside the soft class, not taken
        add_record(cmts_pkg::FMT_MJPG,  720, 1280, 30, 1, 7, 9, cmts_pkg::FLAGS_ONE, 1'b0);
        // valid but outside the soft class
        add_record(cmts_pkg::FMT_MJPG,  4096, 4096, 60, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        // invalid: format, flags, oversize, zero rates
        add_record(FMT_BEYOND, 640, 480, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_MJPG,  640, 480, 30, 1, 1, 1, FLAGS_BAD, 1'b0);
        add_record(cmts_pkg::FMT_MJPG,  4097, 480, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_MJPG,  640, 480, 0, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_MJPG,  640, 480, 30, 0, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        // fps exactly on the soft limit, larger area
        add_record(cmts_pkg::FMT_MJPG,  1920, 1080, 30030, 1001, 3, 4,
                   cmts_pkg::FLAGS_TWO, 1'b1);
        // soft class beats rank; huge rate terms
        add_record(cmts_pkg::FMT_MJPG,  4096, 4096, 31, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_H264,  1921, 1080, 30, 1, 1, 1, cmts_pkg::FLAGS_ONE, 1'b0);
        add_record(cmts_pkg::FMT_H264,  1, 1, ALL_ONES, ALL_ONES, ALL_ONES, 0,
                   cmts_pkg::FLAGS_TWO, 1'b1);
        // all ones everywhere: invalid
        add_record(8'hFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                   8'hFF, 1'b1);
        fill_lists(200, 12);
        drain();

        // Widest limits
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        fill_lists(200, 12);
        drain();

        // Narrowest nonzero limits
        set_config(16'd1, 16'd1, 16'd1, 8'd1);
        fill_lists(150, 12);
        drain();

        // Zero hard bound: nothing is valid
        set_config(16'd0, 16'($urandom), 16'($urandom), 8'($urandom));
        fill_lists(60, 8);
        drain();

        // Output held off while short lists keep coming
        set_config(cmts_pkg::MAX_DIM_RST, cmts_pkg::SOFT_W_RST, cmts_pkg::SOFT_H_RST,
                   cmts_pkg::SOFT_FPS_RST);
        hold_req = 1'b1;
        fill_lists(250, 3);
        drain();

        // Zero soft limits, then random limits
        set_config(16'($urandom_range(1, 8192)), 16'd0, 16'd0, 8'd0);
        fill_lists(250, 30);
        drain();
        for (int p = 0; p < 2; p++)
        begin
            set_config(16'($urandom_range(1, 8192)), 16'($urandom_range(1, 4096)),
                       16'($urandom_range(1, 4096)), 8'($urandom_range(1, 255)));
            fill_lists(250, 30);
            drain();
        end

        // Steady traffic to the end
        jitter = 1'b0;
        set_config(cmts_pkg::MAX_DIM_RST, cmts_pkg::SOFT_W_RST, cmts_pkg::SOFT_H_RST,
                   cmts_pkg::SOFT_FPS_RST);
        fill_lists(250, 12);
        drain();

        if (selections_due.size() != 0)
            report_error($sformatf("%0d selections never reported", selections_due.size()));
        $display("%0d records in %0d lists, %0d selections compared, %0d register writes",
                 n_taken, n_lists, n_checked, n_writes);
        $display("offer side stalled %0d cycles; one long output hold-off, gap-free finish",
                 n_blocked);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/cmts_pkg.sv
hw/rtl/cmts_channels.sv
hw/rtl/camera_media_type_selector_unit.sv
tb/testbench.sv
